// ===== sv/mpm_pkg.sv =====
package mpm_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned PROD_W = 62;
    localparam int unsigned SUM_W = 63;
    localparam int unsigned NCELL = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_00 = 2'd0,
        REG_BASE_01 = 2'd1,
        REG_BASE_10 = 2'd2,
        REG_BASE_11 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic done;
    } mr_ctl_t;

endpackage

// ===== sv/mpm_modred.sv =====
module mpm_modred
    import mpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mr_ctl_t           ctl_in,
    input  logic [SUM_W-1:0]  value,
    input  val_t              modulus,
    output mr_ctl_t           ctl_out,
    output val_t              remainder
);

    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] num_reg;
    logic [VAL_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VAL_W+1:0] shifted;
    logic [VAL_W+1:0] diff;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, num_reg[SUM_W-1]};
    assign diff = shifted - {2'b00, modulus};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= !ctl_in.start && busy_reg && (cnt_reg == CNT_W'(1));
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            num_reg <= value;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SUM_W-2:0], 1'b0};
            if (!diff[VAL_W+1])
                rem_reg <= diff[VAL_W:0];
            else
                rem_reg <= shifted[VAL_W:0];
        end
    end

    assign ctl_out.start = busy_reg;
    assign ctl_out.done = done_reg;
    assign remainder = rem_reg[VAL_W-1:0];

endmodule

// ===== sv/matrix_power_mod_2x2.sv =====
// per exponent bit examined: a multiply into the accumulator when that bit is set, then a squaring, cell by cell
// a zero exponent finishes without any matrix product
// one transaction at a time: busy stays high until done pulses with the result
// built around one shared multiplier and one bit-serial remainder unit
// rst_n clears control and restores the base matrix to [[2,1],[1,1]]
// done is a single-cycle strobe; the receiver cannot stall
module matrix_power_mod_2x2
    import mpm_pkg::*;
#(
    parameter int unsigned EXP_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [VAL_W-1:0]    cfg_data,
    input  logic                start,
    input  logic [31:0]         exponent,
    input  logic [VAL_W-1:0]    modulus,
    output logic                busy,
    output logic                done,
    output logic [VAL_W-1:0]    res_00,
    output logic [VAL_W-1:0]    res_01,
    output logic [VAL_W-1:0]    res_10,
    output logic [VAL_W-1:0]    res_11
);

    localparam int unsigned BIT_W = $clog2(EXP_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_MUL0,
        S_MUL1,
        S_RED,
        S_NEXT
    } state_t;

    state_t state_reg;
    val_t base_reg [NCELL];
    val_t acc_reg [NCELL];
    val_t sq_reg [NCELL];
    val_t tmp_reg [NCELL];
    val_t mod_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [BIT_W-1:0] bit_reg;
    logic sqphase_reg;
    logic [1:0] cell_reg;
    logic [SUM_W-1:0] sum_reg;
    logic busy_reg;
    logic done_reg;

    logic [EXP_BITS-1:0] exp_in;
    val_t xa;
    val_t ya;
    logic [PROD_W-1:0] prod;
    mr_ctl_t red_in;
    mr_ctl_t red_out;
    val_t red_q;

    assign exp_in = EXP_BITS'({{(EXP_BITS > 32 ? EXP_BITS - 32 : 0){1'b0}}, exponent});

    // operand selection for x[r][t] * y[t][c]
    always_comb
    begin
        logic r;
        logic c;
        logic t;
        r = cell_reg[1];
        c = cell_reg[0];
        t = (state_reg == S_MUL1);
        xa = sqphase_reg ? sq_reg[{r, t}] : acc_reg[{r, t}];
        ya = sq_reg[{t, c}];
    end

    assign prod = PROD_W'(xa) * PROD_W'(ya);
    assign red_in.start = (state_reg == S_MUL1);
    assign red_in.done = 1'b0;

    mpm_modred u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (red_in),
        .value     (sum_reg + SUM_W'(prod)),
        .modulus   (mod_reg),
        .ctl_out   (red_out),
        .remainder (red_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            base_reg[0] <= VAL_W'(2);
            base_reg[1] <= VAL_W'(1);
            base_reg[2] <= VAL_W'(1);
            base_reg[3] <= VAL_W'(1);
        end
        else
        begin
            done_reg <= (state_reg == S_BIT) &&
                        (exp_reg == '0 || bit_reg == BIT_W'(EXP_BITS));
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_BASE_00: base_reg[0] <= cfg_data;
                    REG_BASE_01: base_reg[1] <= cfg_data;
                    REG_BASE_10: base_reg[2] <= cfg_data;
                    REG_BASE_11: base_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        state_reg <= S_BIT;
                    end
                end
                S_BIT:
                begin
                    if (exp_reg == '0 || bit_reg == BIT_W'(EXP_BITS))
                    begin
                        busy_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_MUL0;
                end
                S_MUL0: state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_RED;
                S_RED:
                begin
                    if (red_out.done)
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (cell_reg == 2'd3 && sqphase_reg)
                        state_reg <= S_BIT;
                    else
                        state_reg <= S_MUL0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    exp_reg <= exp_in;
                    mod_reg <= (modulus == '0) ? VAL_W'(1) : modulus;
                    bit_reg <= '0;
                    acc_reg[0] <= VAL_W'(1);
                    acc_reg[1] <= '0;
                    acc_reg[2] <= '0;
                    acc_reg[3] <= VAL_W'(1);
                    for (int i = 0; i < NCELL; i++)
                        sq_reg[i] <= base_reg[i];
                end
            end
            S_BIT:
            begin
                cell_reg <= '0;
                sqphase_reg <= !exp_reg[0];
            end
            S_MUL0: sum_reg <= SUM_W'(prod);
            S_RED:
            begin
                if (red_out.done)
                    tmp_reg[cell_reg] <= red_q;
            end
            S_NEXT:
            begin
                cell_reg <= cell_reg + 1'b1;
                if (cell_reg == 2'd3)
                begin
                    if (sqphase_reg)
                    begin
                        sq_reg <= tmp_reg;
                        exp_reg <= exp_reg >> 1;
                        bit_reg <= bit_reg + 1'b1;
                    end
                    else
                        acc_reg <= tmp_reg;
                    sqphase_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res_00 = acc_reg[0];
    assign res_01 = acc_reg[1];
    assign res_10 = acc_reg[2];
    assign res_11 = acc_reg[3];

`ifndef ASSERT_OFF
    a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");
    a_red_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        red_out.done |-> busy)
        else $error("remainder finished while idle");
`endif

endmodule

// ===== tb/tb_matrix_power_mod_2x2.sv =====
`timescale 1ns / 100ps

module tb_matrix_power_mod_2x2;
    import mpm_pkg::*;

    typedef bit [63:0] mat_t [4];

    typedef enum int {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        int          gap_pct;
        cfg_idx_t    idx;
        val_t        data;
        logic [31:0] exp_v;
        val_t        mod_v;
    } entry_t;

    typedef struct {
        val_t r00;
        val_t r01;
        val_t r10;
        val_t r11;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    val_t        cfg_data;
    logic        start;
    logic [31:0] exponent;
    val_t        modulus;
    logic        busy;
    logic        done;
    val_t        res_00;
    val_t        res_01;
    val_t        res_10;
    val_t        res_11;

    entry_t  pending_q[$];
    result_t expected_q[$];
    val_t    base_copy [4];
    int      in_flight;
    int      err_cnt;

    matrix_power_mod_2x2 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .exponent  (exponent),
        .modulus   (modulus),
        .busy      (busy),
        .done      (done),
        .res_00    (res_00),
        .res_01    (res_01),
        .res_10    (res_10),
        .res_11    (res_11)
    );

    function automatic mat_t mat_mul_mod(mat_t x, mat_t y, bit [63:0] m);
        mat_t      tmp;
        bit [63:0] acc;
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                acc = x[r*2] * y[c] + x[r*2+1] * y[2+c];
                tmp[r*2+c] = acc % m;
            end
        end
        return tmp;
    endfunction

    function automatic result_t matrix_power(logic [31:0] e, val_t m_in);
        mat_t      acc;
        mat_t      sq;
        bit [63:0] m;
        bit [31:0] left;
        result_t   res;
        m = (m_in == 0) ? 64'd1 : 64'(m_in);
        left = e;
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = (i == 0 || i == 3) ? 64'd1 : 64'd0;
            sq[i] = 64'(base_copy[i]);
        end
        while (left != 0)
        begin
            if (left[0])
                acc = mat_mul_mod(acc, sq, m);
            left = left >> 1;
            sq = mat_mul_mod(sq, sq, m);
        end
        res.r00 = acc[0][30:0];
        res.r01 = acc[1][30:0];
        res.r10 = acc[2][30:0];
        res.r11 = acc[3][30:0];
        return res;
    endfunction

    task automatic add_item(logic [31:0] e, val_t m, int gap);
        entry_t en;
        en.kind = ENT_ITEM;
        en.gap_pct = gap;
        en.idx = REG_BASE_00;
        en.data = '0;
        en.exp_v = e;
        en.mod_v = m;
        pending_q.push_back(en);
    endtask

    task automatic add_cfg(cfg_idx_t idx, val_t d);
        entry_t en;
        en.kind = ENT_CFG;
        en.gap_pct = 0;
        en.idx = idx;
        en.data = d;
        en.exp_v = '0;
        en.mod_v = '0;
        pending_q.push_back(en);
    endtask

    task automatic add_drain();
        entry_t en;
        en.kind = ENT_DRAIN;
        en.gap_pct = 0;
        en.idx = REG_BASE_00;
        en.data = '0;
        en.exp_v = '0;
        en.mod_v = '0;
        pending_q.push_back(en);
    endtask

    task automatic add_base(val_t a, val_t b, val_t c, val_t d);
        add_cfg(REG_BASE_00, a);
        add_cfg(REG_BASE_01, b);
        add_cfg(REG_BASE_10, c);
        add_cfg(REG_BASE_11, d);
    endtask

    function automatic val_t rand_val();
        if ($urandom_range(0, 3) == 0)
            return val_t'($urandom_range(0, 20));
        return val_t'($urandom);
    endfunction

    function automatic logic [31:0] rand_exp();
        if ($urandom_range(0, 99) < 12)
            return $urandom;
        return $urandom & ((32'd1 << $urandom_range(0, 8)) - 32'd1);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: one queue entry at a time, start held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        logic we_v;
        we_v = 1'b0;
        if (!rst_n)
        begin
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            start <= 1'b0;
            exponent <= '0;
            modulus <= '0;
            in_flight = 0;
            base_copy[0] = 31'd2;
            base_copy[1] = 31'd1;
            base_copy[2] = 31'd1;
            base_copy[3] = 31'd1;
        end
        else
        begin
            if (done)
                in_flight = in_flight - 1;
            if (start && !busy)
            begin
                expected_q.push_back(matrix_power(exponent, modulus));
                in_flight = in_flight + 1;
            end
            if (!(start && busy))
            begin
                if (pending_q.size() == 0)
                    start <= 1'b0;
                else if (pending_q[0].kind == ENT_ITEM)
                begin
                    if ($urandom_range(0, 99) < pending_q[0].gap_pct)
                        start <= 1'b0;
                    else
                    begin
                        start <= 1'b1;
                        exponent <= pending_q[0].exp_v;
                        modulus <= pending_q[0].mod_v;
                        void'(pending_q.pop_front());
                    end
                end
                else
                begin
                    start <= 1'b0;
                    if (in_flight == 0 && !busy && !start)
                    begin
                        if (pending_q[0].kind == ENT_CFG)
                        begin
                            we_v = 1'b1;
                            cfg_index <= pending_q[0].idx;
                            cfg_data <= pending_q[0].data;
                            base_copy[pending_q[0].idx] = pending_q[0].data;
                        end
                        void'(pending_q.pop_front());
                    end
                end
            end
            cfg_we <= we_v;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction");
                err_cnt++;
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (res_00 !== e.r00)
                begin
                    $error("res_00 expected %0d actual %0d", e.r00, res_00);
                    err_cnt++;
                end
                if (res_01 !== e.r01)
                begin
                    $error("res_01 expected %0d actual %0d", e.r01, res_01);
                    err_cnt++;
                end
                if (res_10 !== e.r10)
                begin
                    $error("res_10 expected %0d actual %0d", e.r10, res_10);
                    err_cnt++;
                end
                if (res_11 !== e.r11)
                begin
                    $error("res_11 expected %0d actual %0d", e.r11, res_11);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int gaps [4];
        err_cnt = 0;
        gaps[0] = 0;
        gaps[1] = 63;
        gaps[2] = 13;
        gaps[3] = 0;

        // reset base matrix, identity and modulus corner cases
        add_item(32'd0, 31'd1, 0);
        add_item(32'd0, 31'd0, 0);
        add_item(32'd5, 31'd0, 0);
        add_item(32'd1, 31'h7fffffff, 0);
        add_item(32'd1, 31'd1, 0);
        add_item(32'd10, 31'd1000, 0);
        add_item(32'hffffffff, 31'h7fffffff, 0);
        add_item(32'h80000000, 31'h7ffffffe, 0);
        add_item(32'd3, 31'd2, 0);
        add_drain();
        // base entries below, at and above the modulus, including an all-zero base
        add_base(31'h7ffffffe, 31'h7ffffffe, 31'h7ffffffe, 31'h7ffffffe);
        add_item(32'd1, 31'd5, 0);
        add_item(32'hffffffff, 31'h7fffffff, 0);
        add_item(32'h55555555, 31'd3, 0);
        add_item(32'd0, 31'd7, 0);
        add_base(31'd0, 31'd0, 31'd0, 31'd0);
        add_item(32'd7, 31'd13, 0);
        add_item(32'd0, 31'd0, 0);
        add_base(31'h7fffffff, 31'd0, 31'h2aaaaaaa, 31'h55555555);
        add_item(32'haaaaaaaa, 31'h7fffffff, 0);
        add_item(32'd2, 31'd100, 0);
        add_drain();

        for (int p = 0; p < 4; p++)
        begin
            add_base(rand_val(), rand_val(), rand_val(), rand_val());
            for (int i = 0; i < 21; i++)
            begin
                add_item(rand_exp(), ($urandom_range(0, 3) == 0) ?
                         val_t'($urandom_range(0, 16)) : val_t'($urandom), gaps[p]);
                if (i == 12)
                    add_drain();
            end
        end

        while (pending_q.size() != 0 || start || in_flight != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_matrix_power_mod_2x2: done, clean");
        else
            $display("tb_matrix_power_mod_2x2: done, errors");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("tb_matrix_power_mod_2x2: done, errors");
        $finish;
    end

endmodule
